FILE: rtl/ddpi_pkg.sv
// Shared types and constants for the differential-drive pose integrator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package ddpi_pkg;

    // CORDIC datapath widths: x/y at scale 2^30 with headroom, z as a signed angle
    localparam int X_W          = 34;
    localparam int Z_W          = 33;
    localparam int ATAN_ENTRIES = 24;

    // CORDIC start value: gain compensation 0.607252935 at scale 2^30
    localparam logic signed [X_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Register map (word index taken from paddr[2])
    localparam logic REG_SAMPLE_PERIOD = 1'b0;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [23:0] angular_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic               position_clipped;
    } t_out_item;

    // Payload handed from cell to cell
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic        [1:0]     quad;
    } t_cord;

    // Sine and cosine, Q1.15
    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } t_sincos;

    // atan(2^-i) as a binary angle, full turn = 2^32
    function automatic logic signed [Z_W-1:0] atan_val(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 33'sd536870912;
            1:       v = 33'sd316933406;
            2:       v = 33'sd167458907;
            3:       v = 33'sd85004756;
            4:       v = 33'sd42667331;
            5:       v = 33'sd21354465;
            6:       v = 33'sd10679838;
            7:       v = 33'sd5340245;
            8:       v = 33'sd2670163;
            9:       v = 33'sd1335087;
            10:      v = 33'sd667544;
            11:      v = 33'sd333772;
            12:      v = 33'sd166886;
            13:      v = 33'sd83443;
            14:      v = 33'sd41722;
            15:      v = 33'sd20861;
            16:      v = 33'sd10430;
            17:      v = 33'sd5215;
            18:      v = 33'sd2608;
            19:      v = 33'sd1304;
            20:      v = 33'sd652;
            21:      v = 33'sd326;
            22:      v = 33'sd163;
            23:      v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/differential_drive_pose_integrator.sv
// Dead-reckoning pose integrator: one transaction in, one pose out (Euler step).
// One transaction at a time: a new one is accepted only after the previous pose is committed,
// and the commit waits while the output register holds a result that has not been taken.
// Reset (synchronous, i_rst_n low): pose = 0, sample_period = 655, output empty.
// Depends on ddpi_pkg, ddpi_cordic, ddpi_cordic_cell.
`default_nettype none

module differential_drive_pose_integrator
    import ddpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input transaction: speeds at the kinematic center
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // output transaction: updated pose
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out_item   o_out_data,
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // waiting for a transaction
        S_CORD = 5'b00010,  // sin/cos of the old heading in flight
        S_MULS = 5'b00100,  // D * sin
        S_MULC = 5'b01000,  // D * cos, round x step
        S_UPD  = 5'b10000   // round y step, saturate, commit pose
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [15:0]        r_sample_period;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [31:0]        r_hd;

    logic signed [32:0] r_dist;    // V*T, 2^-24 m
    logic signed [23:0] r_w;
    logic [31:0]        r_wt;      // W*T, 2^-32 turn
    t_sincos            r_sc;
    logic signed [48:0] r_prod;
    logic signed [25:0] r_dx;

    t_out_item          r_out;
    logic               r_out_vld;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_cord_vld;
    t_sincos            w_cord_sc;
    logic signed [16:0] w_t;

    // ------------------------------------------------------------------
    // Register port: one register, zero wait states
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SAMPLE_PERIOD)) begin
            r_sample_period <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_SAMPLE_PERIOD) ? {16'd0, r_sample_period} : '0;

    assign w_t = $signed({1'b0, r_sample_period});

    // ------------------------------------------------------------------
    // Control: one transaction at a time; the next one waits on the
    // pose that this one commits in S_UPD.
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc)   n_state = S_CORD;
            S_CORD:  if (w_cord_vld) n_state = S_MULS;
            S_MULS:  n_state = S_MULC;
            S_MULC:  n_state = S_UPD;
            S_UPD:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Sine/cosine of the old heading, started with the transaction
    // ------------------------------------------------------------------
    ddpi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_in_acc),
        .i_angle (r_hd),
        .o_vld   (w_cord_vld),
        .o_sc    (w_cord_sc)
    );

    // ------------------------------------------------------------------
    // Datapath. One 33x16 multiplier shared by the sin and cos products.
    // ------------------------------------------------------------------
    logic signed [15:0] w_mul_b;
    logic signed [48:0] w_prod;
    logic signed [40:0] w_wt;
    logic signed [48:0] w_rnd;
    logic signed [25:0] w_step;

    assign w_mul_b = (r_state == S_MULS) ? r_sc.s : r_sc.c;
    assign w_prod  = r_dist * w_mul_b;
    assign w_wt    = r_w * w_t;

    // floor((p + 2^22) / 2^23): round half up to 2^-16 m
    assign w_rnd  = r_prod + 49'sd4194304;
    assign w_step = w_rnd[48:23];

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dist <= i_in_data.linear_speed * w_t;
            r_w    <= i_in_data.angular_speed;
        end
        if ((r_state == S_CORD) && w_cord_vld) begin
            r_sc <= w_cord_sc;
        end
        if (r_state == S_MULS) begin
            r_prod <= w_prod;
            r_wt   <= w_wt[31:0];
        end
        if (r_state == S_MULC) begin
            r_dx   <= w_step;
            r_prod <= w_prod;
        end
    end

    // new position with saturation to int32
    logic signed [33:0] w_nx;
    logic signed [33:0] w_ny;
    logic signed [31:0] w_sx;
    logic signed [31:0] w_sy;
    logic               w_clip_x;
    logic               w_clip_y;

    assign w_nx = 34'(r_x) - 34'(r_dx);
    assign w_ny = 34'(r_y) + 34'(w_step);

    assign w_clip_x = (w_nx[33:31] != 3'b000) && (w_nx[33:31] != 3'b111);
    assign w_clip_y = (w_ny[33:31] != 3'b000) && (w_ny[33:31] != 3'b111);

    always_comb begin
        if (w_clip_x) begin
            w_sx = w_nx[33] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            w_sx = w_nx[31:0];
        end
        if (w_clip_y) begin
            w_sy = w_ny[33] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            w_sy = w_ny[31:0];
        end
    end

    // pose state and the output register
    logic w_commit;
    assign w_commit = (r_state == S_UPD) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_hd      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_commit) begin
                r_x       <= w_sx;
                r_y       <= w_sy;
                r_hd      <= r_hd + r_wt;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.pos_x            <= w_sx;
            r_out.pos_y            <= w_sy;
            r_out.heading          <= r_hd + r_wt;
            r_out.position_clipped <= w_clip_x || w_clip_y;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/ddpi_cordic_cell.sv
// One CORDIC rotation-mode cell: a fixed shift and one atan constant, registered.
// Depends on ddpi_pkg.
`default_nettype none

module ddpi_cordic_cell
    import ddpi_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_vld,
    input  t_cord i_d,
    output logic  o_vld,
    output t_cord o_d
);

    localparam logic signed [Z_W-1:0] ATAN = atan_val(STAGE);

    logic  r_vld;
    t_cord r_d;
    t_cord n_d;
    logic signed [X_W-1:0] w_dx;
    logic signed [X_W-1:0] w_dy;

    // arithmetic shift == floor division by 2^STAGE
    assign w_dx = i_d.y >>> STAGE;
    assign w_dy = i_d.x >>> STAGE;

    always_comb begin
        n_d.quad = i_d.quad;
        if (!i_d.z[Z_W-1]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

FILE: rtl/ddpi_cordic.sv
// Sine/cosine unit: quadrant fold, a chain of CORDIC cells, Q1.15 rounding and
// quadrant rotation. Depends on ddpi_pkg and ddpi_cordic_cell.
`default_nettype none

module ddpi_cordic
    import ddpi_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_vld,
    input  wire  [31:0] i_angle,
    output logic        o_vld,
    output t_sincos     o_sc
);

    t_cord w_d [0:STEPS];
    logic  w_v [0:STEPS];

    logic       r_fold_vld;
    t_cord      r_fold;
    logic [1:0] w_quad;
    logic [31:0] w_resid;

    // nearest quadrant; residual lands in [-1/8, 1/8) turn
    assign w_quad  = i_angle[31:30] + {1'b0, i_angle[29]};
    assign w_resid = i_angle - {w_quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_vld <= 1'b0;
        end else begin
            r_fold_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_fold.x    <= CORDIC_X0;
            r_fold.y    <= '0;
            r_fold.z    <= {w_resid[31], w_resid};
            r_fold.quad <= w_quad;
        end
    end

    assign w_d[0] = r_fold;
    assign w_v[0] = r_fold_vld;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        ddpi_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_v[k]),
            .i_d     (w_d[k]),
            .o_vld   (w_v[k+1]),
            .o_d     (w_d[k+1])
        );
    end

    // floor((v + 2^14) / 2^15), clamped to 16 bits signed; kept 17 wide for negation
    function automatic logic signed [16:0] to_q15(input logic signed [X_W-1:0] v);
        logic signed [X_W-1:0]    sum;
        logic signed [X_W-16:0]   sh;
        logic signed [16:0]       r;
        sum = v + X_W'(16384);
        sh  = sum[X_W-1:15];
        if (sh > 32767) begin
            r = 17'sd32767;
        end else if (sh < -32768) begin
            r = -17'sd32768;
        end else begin
            r = sh[16:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_hi(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'sh7fff;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic signed [16:0] w_c;
    logic signed [16:0] w_s;
    t_sincos            n_sc;
    t_sincos            r_sc;
    logic               r_vld;

    assign w_c = to_q15(w_d[STEPS].x);
    assign w_s = to_q15(w_d[STEPS].y);

    always_comb begin
        case (w_d[STEPS].quad)
            2'd0: begin
                n_sc.c = clamp_hi(w_c);
                n_sc.s = clamp_hi(w_s);
            end
            2'd1: begin
                n_sc.c = clamp_hi(-w_s);
                n_sc.s = clamp_hi(w_c);
            end
            2'd2: begin
                n_sc.c = clamp_hi(-w_c);
                n_sc.s = clamp_hi(-w_s);
            end
            default: begin
                n_sc.c = clamp_hi(w_s);
                n_sc.s = clamp_hi(-w_c);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_v[STEPS]) begin
            r_sc <= n_sc;
        end
    end

    assign o_vld = r_vld;
    assign o_sc  = r_sc;

endmodule

`default_nettype wire

FILE: rtl/ddpi_checker.sv
// Port-level checks for the pose integrator, attached by bind.
// Depends on ddpi_pkg and differential_drive_pose_integrator.
`default_nettype none

module ddpi_checker
    import ddpi_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input t_out_item o_out_data
);

    // one transaction in flight: ready drops right after an input transaction
    a_seq_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a transaction was in flight");

    // a pending result holds until taken
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction dropped or changed while stalled");

    // the clip flag only comes with a coordinate at an int32 limit
    a_clip : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.position_clipped) |->
            (o_out_data.pos_x == 32'sh7fffffff || o_out_data.pos_x == 32'sh80000000 ||
             o_out_data.pos_y == 32'sh7fffffff || o_out_data.pos_y == 32'sh80000000))
        else $error("clip flag without a saturated coordinate");

    // results need the full CORDIC chain: none appears right after an input
    a_no_early : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("output appeared one cycle after input");

    // reset empties the output register
    a_rst : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind differential_drive_pose_integrator ddpi_checker u_ddpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
